// ===== rtl/core/tfs_pkg.sv =====
// shared types and constants of the tuner frequency serializer
package tfs_pkg;

   localparam int unsigned FREQ_WIDTH   = 22;
   localparam int unsigned DIVIDER_BITS = 13;
   localparam int unsigned PAD_ZEROS    = 7;
   localparam int unsigned FRAME_BITS   = 1 + DIVIDER_BITS + PAD_ZEROS + 3;
   localparam int unsigned RUN_BYTES    = 2 * FRAME_BITS + 1;
   localparam int unsigned COUNT_WIDTH  = $clog2(RUN_BYTES);
   localparam int unsigned SUM_WIDTH    = FREQ_WIDTH + 1;

   // divide by 800 as a shift by 5 and a reciprocal multiply for 25
   localparam int unsigned DIV_SHIFT    = 5;
   localparam int unsigned QUOT_IN_BITS = SUM_WIDTH - DIV_SHIFT;
   localparam int unsigned RECIP_SHIFT  = 30;
   localparam int unsigned RECIP_BITS   = 26;
   localparam int unsigned PROD_WIDTH   = QUOT_IN_BITS + RECIP_BITS;

   localparam logic [SUM_WIDTH-1:0]   FREQ_OFFSET = SUM_WIDTH'(171200);
   localparam logic [RECIP_BITS-1:0]  RECIP_25    = RECIP_BITS'(42949673);

   localparam logic [2:0]  FRAME_TAIL = 3'b101;
   localparam logic [7:0]  BYTE_BASE  = 8'hD1;
   localparam logic [7:0]  BIT_ONE    = 8'h04;
   localparam logic [7:0]  AUDIO_ON   = 8'h08;
   localparam logic [7:0]  CLOCK_HIGH = 8'h02;
   localparam logic [7:0]  END_OFF    = 8'hD0;
   localparam logic [7:0]  END_ON     = 8'hD8;

   localparam logic [COUNT_WIDTH-1:0] LAST_INDEX = COUNT_WIDTH'(RUN_BYTES - 1);

   typedef struct packed {
      logic [FREQ_WIDTH-1:0] freq;
      logic                  audio_off;
   } req_type;

   typedef struct packed {
      logic [7:0] port_value;
      logic       last;
   } rsp_type;

endpackage

// ===== rtl/core/tfs_frame_build.sv =====
// pll divider computation and 24-bit frame assembly
module tfs_frame_build (
   input  logic [tfs_pkg::FREQ_WIDTH-1:0] freq,
   output logic [tfs_pkg::FRAME_BITS-1:0] frame
);

   logic [tfs_pkg::SUM_WIDTH-1:0]    sum;
   logic [tfs_pkg::QUOT_IN_BITS-1:0] scaled;
   logic [tfs_pkg::PROD_WIDTH-1:0]   prod;
   logic [tfs_pkg::DIVIDER_BITS-1:0] divider;

   assign sum    = tfs_pkg::SUM_WIDTH'(freq) + tfs_pkg::FREQ_OFFSET;
   assign scaled = sum[tfs_pkg::SUM_WIDTH-1:tfs_pkg::DIV_SHIFT];
   // reciprocal error is below one part in 2^30, exact for every 18-bit input
   assign prod   = tfs_pkg::PROD_WIDTH'(scaled) * tfs_pkg::PROD_WIDTH'(tfs_pkg::RECIP_25);
   assign divider = prod[tfs_pkg::RECIP_SHIFT +: tfs_pkg::DIVIDER_BITS];

   // bit 0 goes out first: zero, divider lsb first, padding, then 1 0 1
   assign frame = {tfs_pkg::FRAME_TAIL, tfs_pkg::PAD_ZEROS'(0), divider, 1'b0};

endmodule

// ===== rtl/core/tuner_frequency_serializer_unit.sv =====
// tuner frequency serializer: request register, frame build and byte serializer
// an accepted request is held in the request register, then loaded into the serializer, which raises rsp_valid
// throughput: 49 result bytes per item, one per cycle while rsp_ready is high, set by the byte serializer
// a second item waits in the request register, so runs follow with no gap
// reset (synchronous, active high) empties the request register and the serializer
module tuner_frequency_serializer_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tfs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tfs_pkg::rsp_type rsp_data
);

   logic                              hold_valid_ff, hold_valid_in;
   tfs_pkg::req_type                  hold_ff, hold_in;
   logic                              busy_ff, busy_in;
   logic [tfs_pkg::COUNT_WIDTH-1:0]   count_ff, count_in;
   logic [tfs_pkg::FRAME_BITS-1:0]    frame_ff, frame_in;
   logic                              audio_on_ff, audio_on_in;

   logic [tfs_pkg::FRAME_BITS-1:0]    frame_new;
   logic                              last_now;
   logic                              load;
   logic                              advance;
   logic [7:0]                        data_byte;

   tfs_frame_build u_frame_build (
      .freq  (hold_ff.freq),
      .frame (frame_new)
   );

   assign last_now  = (count_ff == tfs_pkg::LAST_INDEX);
   assign advance   = busy_ff && rsp_ready;
   assign load      = hold_valid_ff && (!busy_ff || (rsp_ready && last_now));
   assign req_ready = !hold_valid_ff || load;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      if (req_valid && req_ready) begin
         hold_valid_in = 1'b1;
         hold_in       = req_data;
      end else if (load) begin
         hold_valid_in = 1'b0;
      end
   end

   always_comb begin
      busy_in     = busy_ff;
      count_in    = count_ff;
      frame_in    = frame_ff;
      audio_on_in = audio_on_ff;
      priority if (load) begin
         busy_in     = 1'b1;
         count_in    = '0;
         frame_in    = frame_new;
         audio_on_in = !hold_ff.audio_off;
      end else if (advance) begin
         busy_in  = !last_now;
         count_in = count_ff + 1'b1;
         // next frame bit after the clock-high byte
         if (count_ff[0]) begin
            frame_in = frame_ff >> 1;
         end
      end else begin
         // idle, or the current byte is stalled
         busy_in = busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         busy_ff       <= 1'b0;
         count_ff      <= '0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         busy_ff       <= busy_in;
         count_ff      <= count_in;
      end
      hold_ff     <= hold_in;
      frame_ff    <= frame_in;
      audio_on_ff <= audio_on_in;
   end

   assign data_byte = tfs_pkg::BYTE_BASE
                    | (frame_ff[0] ? tfs_pkg::BIT_ONE    : 8'h00)
                    | (audio_on_ff ? tfs_pkg::AUDIO_ON   : 8'h00)
                    | (count_ff[0] ? tfs_pkg::CLOCK_HIGH : 8'h00);

   assign rsp_valid           = busy_ff;
   assign rsp_data.last       = last_now;
   assign rsp_data.port_value = last_now
                              ? (audio_on_ff ? tfs_pkg::END_ON : tfs_pkg::END_OFF)
                              : data_byte;

endmodule

// ===== rtl/core/tfs_checker.sv =====
// port-level checks of the tuner frequency serializer, bound to the top level
module tfs_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input tfs_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input tfs_pkg::rsp_type rsp_data
);

   // a stalled result byte holds
   rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed while stalled");

   // a run never breaks before its closing byte
   run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.last |=> rsp_valid)
      else $error("run ended without a closing byte");

   // closing byte is one of the two end codes
   end_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |->
         rsp_data.port_value == tfs_pkg::END_OFF ||
         rsp_data.port_value == tfs_pkg::END_ON)
      else $error("bad closing byte");

   // every data byte keeps the fixed high nibble and bit 0
   data_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |->
         rsp_data.port_value[7:4] == tfs_pkg::BYTE_BASE[7:4] && rsp_data.port_value[0])
      else $error("bad data byte");

   // an item taken while idle starts its run once it has passed the request register into the serializer
   start_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid && !$isunknown(req_data) |-> ##2 rsp_valid)
      else $error("run did not start");

endmodule

bind tuner_frequency_serializer_unit tfs_checker u_tfs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== dv/tb_tuner_frequency_serializer_unit.sv =====
// testbench of the tuner frequency serializer: random requests, byte-by-byte frame check
module tb_tuner_frequency_serializer_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned TUNE_OFFSET  = 171200;
   localparam int unsigned TUNE_STEP    = 800;
   localparam int unsigned PLL_BITS     = 13;
   localparam int unsigned FRAME_LEN    = 24;
   localparam int unsigned FREQ_MAX     = 4194303;
   localparam logic [7:0]  PORT_BASE    = 8'hD1;
   localparam logic [7:0]  PORT_DATA    = 8'h04;
   localparam logic [7:0]  PORT_AUDIO   = 8'h08;
   localparam logic [7:0]  PORT_CLOCK   = 8'h02;
   localparam logic [7:0]  CLOSE_MUTED  = 8'hD0;
   localparam logic [7:0]  CLOSE_AUDIO  = 8'hD8;
   localparam int          RANDOM_ITEMS = 200;
   localparam int          HOLD_AT      = 700;
   localparam int          HOLD_CYCLES  = 300;

   class tuning_scoreboard;
      tfs_pkg::rsp_type port_bytes[$];
      int               error_count;

      function new();
         error_count = 0;
      endfunction

      // expands one accepted request into its 49 port bytes
      function void note_request(tfs_pkg::req_type item);
         logic [31:0]          freq_ext;
         logic [31:0]          divider;
         logic [FRAME_LEN-1:0] frame;
         logic [7:0]           low_byte;
         logic                 audio_on;
         tfs_pkg::rsp_type     entry;
         freq_ext = {10'd0, item.freq};
         divider  = (freq_ext + TUNE_OFFSET) / TUNE_STEP;
         audio_on = ~item.audio_off;
         // frame in send order: start zero, divider lsb first, padding, tail 1 0 1
         frame = '0;
         for (int i = 0; i < PLL_BITS; i++)
            frame[1 + i] = divider[i];
         frame[FRAME_LEN - 3] = 1'b1;
         frame[FRAME_LEN - 1] = 1'b1;
         for (int k = 0; k < FRAME_LEN; k++) begin
            low_byte = PORT_BASE + (frame[k] ? PORT_DATA : 8'h00)
                       + (audio_on ? PORT_AUDIO : 8'h00);
            entry.port_value = low_byte;
            entry.last       = 1'b0;
            port_bytes.push_back(entry);
            entry.port_value = low_byte + PORT_CLOCK;
            port_bytes.push_back(entry);
         end
         entry.port_value = audio_on ? CLOSE_AUDIO : CLOSE_MUTED;
         entry.last       = 1'b1;
         port_bytes.push_back(entry);
      endfunction

      function void check_result(tfs_pkg::rsp_type got);
         tfs_pkg::rsp_type want;
         if (port_bytes.size() == 0) begin
            $display("%0t: unexpected byte, expected none, actual %h last %b",
                     $time, got.port_value, got.last);
            error_count++;
            return;
         end
         want = port_bytes.pop_front();
         if (got.port_value !== want.port_value) begin
            $display("%0t: port_value mismatch, expected %h, actual %h",
                     $time, want.port_value, got.port_value);
            error_count++;
         end
         if (got.last !== want.last) begin
            $display("%0t: last mismatch, expected %b, actual %b",
                     $time, want.last, got.last);
            error_count++;
         end
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   tfs_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   tfs_pkg::rsp_type rsp_data;

   tuning_scoreboard board = new();
   bit               req_calm;

   tuner_frequency_serializer_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   function automatic tfs_pkg::req_type make_request(
      logic [tfs_pkg::FREQ_WIDTH-1:0] freq,
      logic                           audio_off
   );
      tfs_pkg::req_type item;
      item.freq      = freq;
      item.audio_off = audio_off;
      return item;
   endfunction

   // mix of full-range values, broadcast band, divider step edges and extremes
   function automatic logic [tfs_pkg::FREQ_WIDTH-1:0] pick_freq();
      int unsigned step_index;
      logic [31:0] value;
      case ($urandom_range(0, 3))
         0: value = $urandom & 32'h003F_FFFF;
         1: value = $urandom_range(1408000, 1728000);
         2: begin
            step_index = $urandom_range(215, 5456);
            value = step_index * TUNE_STEP - TUNE_OFFSET - $urandom_range(0, 1);
         end
         default: begin
            case ($urandom_range(0, 2))
               0: value = $urandom_range(0, 15);
               1: value = FREQ_MAX - $urandom_range(0, 15);
               default: value = $urandom_range(0, 1) ? 32'h002A_AAAA : 32'h0015_5555;
            endcase
         end
      endcase
      return value[tfs_pkg::FREQ_WIDTH-1:0];
   endfunction

   task automatic drive_request(tfs_pkg::req_type item);
      int gap;
      gap = req_calm ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      board.note_request(item);
   endtask

   initial begin : req_side
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_ready = 1'b0;
      req_calm  = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, both audio states, divider step edges, bit patterns
      drive_request(make_request(22'd0, 1'b0));
      drive_request(make_request(22'd0, 1'b1));
      drive_request(make_request(22'(FREQ_MAX), 1'b0));
      drive_request(make_request(22'(FREQ_MAX), 1'b1));
      drive_request(make_request(22'd68800, 1'b0));
      drive_request(make_request(22'd68799, 1'b0));
      drive_request(make_request(22'd799, 1'b1));
      drive_request(make_request(22'd800, 1'b1));
      drive_request(make_request(22'h2AAAAA, 1'b0));
      drive_request(make_request(22'h155555, 1'b1));
      drive_request(make_request(22'd1600000, 1'b0));
      drive_request(make_request(22'd4193600, 1'b1));

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 25 == 0)
            req_calm = ($urandom_range(0, 2) == 0);
         drive_request(make_request(pick_freq(), 1'($urandom_range(0, 1))));
      end
      req_valid <= 1'b0;

      while (board.port_bytes.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (board.port_bytes.size() != 0) begin
         $display("%0t: %0d expected bytes never arrived", $time, board.port_bytes.size());
         board.error_count++;
      end
      if (board.error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   initial begin : rsp_side
      int stall;
      int received;
      bit calm;
      received = 0;
      calm     = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (received % 150 == 0)
            calm = ($urandom_range(0, 2) == 0);
         // one long hold-off so the request register fills and the input stalls
         if (received == HOLD_AT)
            stall = HOLD_CYCLES;
         else if (calm)
            stall = 0;
         else
            stall = $urandom_range(0, 6);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         board.check_result(rsp_data);
         received++;
      end
   end

   initial begin : watchdog
      #5_000_000;
      $display("%0t: timeout", $time);
      $display("Simulation FAILED");
      $finish;
   end

endmodule
